>>> rtl/core/gltw_pkg.sv
// Shared types and constants for the greedy text line wrapper.
// No dependencies; used by every module under rtl/core.
package gltw_pkg;

    localparam int POS_W     = 12;
    localparam int LEN_W     = 13;
    localparam int WIDTH_W   = 13;
    localparam int CODE_W    = 16;
    localparam int ADV_W     = 8;
    localparam int WRAP_W    = 12;
    localparam int MINW_W    = 8;
    localparam int MAX_RECS  = 3;
    localparam int REC_CNT_W = 2;
    localparam int FIFO_DEPTH_DEFAULT = 4;

    localparam logic [CODE_W-1:0] CODE_NEWLINE = 16'd10;
    localparam logic [CODE_W-1:0] CODE_SPACE   = 16'd32;

    localparam logic KIND_LINE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic CFG_WRAP_WIDTH = 1'b0;
    localparam logic CFG_MIN_WIDTH  = 1'b1;

    localparam logic [WRAP_W-1:0] WRAP_WIDTH_RESET = 12'd1024;
    localparam logic [MINW_W-1:0] MIN_WIDTH_RESET  = 8'd0;

    typedef struct packed {
        logic [POS_W-1:0]   pos;
        logic [POS_W-1:0]   start;
        logic [WIDTH_W-1:0] width;
        logic               open;
        logic               skip;
    } gltw_state_t;

    typedef struct packed {
        logic             kind;
        logic [POS_W-1:0] start;
        logic [LEN_W-1:0] len;
    } gltw_rec_t;

endpackage

>>> rtl/core/gltw_step.sv
// Combinational line-breaking decision for one character.
// Depends on gltw_pkg for the state and record types.
module gltw_step
    import gltw_pkg::*;
(
    input  gltw_state_t                   state_cur,
    input  logic [CODE_W-1:0]             code,
    input  logic [ADV_W-1:0]              adv,
    input  logic                          last,
    input  logic [WRAP_W-1:0]             wrap_width,
    input  logic [MINW_W-1:0]             min_width,
    output gltw_state_t                   state_nxt,
    output gltw_rec_t [MAX_RECS-1:0]      recs,
    output logic [REC_CNT_W-1:0]          rec_count
);

    always_comb
    begin
        gltw_state_t             s;
        logic [POS_W-1:0]        p;
        logic [POS_W-1:0]        span;
        logic [WIDTH_W:0]        w;
        logic [REC_CNT_W-1:0]    k;

        s    = state_cur;
        p    = state_cur.pos;
        k    = '0;
        w    = '0;
        span = '0;
        recs = '0;

        if (wrap_width < {4'b0, min_width})
        begin
            s.open  = 1'b0;
            s.skip  = 1'b0;
            s.width = '0;
        end
        else if (!(s.skip && code == CODE_SPACE))
        begin
            s.skip = 1'b0;
            if (!s.open)
            begin
                s.open  = 1'b1;
                s.start = p;
                s.width = '0;
            end
            span = p - s.start;
            if (code == CODE_NEWLINE)
            begin
                recs[k] = '{kind: KIND_LINE, start: s.start, len: {1'b0, span}};
                k       = k + 2'd1;
                s.open  = 1'b0;
                s.width = '0;
            end
            else
            begin
                w = {1'b0, s.width} + {6'b0, adv};
                if (w <= {2'b0, wrap_width})
                begin
                    s.width = w[WIDTH_W-1:0];
                end
                else
                begin
                    if (p != s.start)
                    begin
                        recs[k] = '{kind: KIND_LINE, start: s.start, len: {1'b0, span}};
                        k       = k + 2'd1;
                        if (code == CODE_SPACE)
                        begin
                            s.open  = 1'b0;
                            s.skip  = 1'b1;
                            s.width = '0;
                        end
                        else
                        begin
                            s.start = p;
                            s.width = {5'b0, adv};
                        end
                    end
                    // A glyph wider than the whole line sits alone on its own line.
                    if (s.open && {4'b0, adv} > wrap_width)
                    begin
                        recs[k] = '{kind: KIND_LINE, start: p, len: 13'd1};
                        k       = k + 2'd1;
                        s.open  = 1'b0;
                        s.skip  = 1'b1;
                        s.width = '0;
                    end
                end
            end
        end

        if (last)
        begin
            if (s.open)
            begin
                span    = p - s.start;
                recs[k] = '{kind: KIND_LINE, start: s.start,
                            len: {1'b0, span} + 13'd1};
                k       = k + 2'd1;
            end
            recs[k] = '{kind: KIND_END, start: '0, len: '0};
            k       = k + 2'd1;
            s       = '0;
        end
        else
        begin
            s.pos = p + 12'd1;
        end

        state_nxt = s;
        rec_count = k;
    end

endmodule

>>> rtl/core/gltw_rec_fifo.sv
// Small record queue: takes up to three records per cycle, gives one per cycle.
// Depends on gltw_pkg for the record type; depth must be a power of two.
module gltw_rec_fifo
    import gltw_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  logic [REC_CNT_W-1:0]      push_count,
    input  gltw_rec_t [MAX_RECS-1:0]  push_recs,
    output logic                      room,
    input  logic                      pop,
    output logic                      head_valid,
    output gltw_rec_t                 head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    gltw_rec_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] add_cnt;
    logic             do_pop;

    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign room       = (count_reg <= CNT_W'(DEPTH - MAX_RECS));
    assign do_pop     = pop && head_valid;
    assign add_cnt    = push ? CNT_W'(push_count) : '0;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(add_cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(do_pop);
        count_next  = count_reg + add_cnt - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RECS; i++)
        begin
            if (push && REC_CNT_W'(i) < push_count)
            begin
                mem_reg[wr_ptr_reg + PTR_W'(i)] <= push_recs[i];
            end
        end
    end

endmodule

>>> rtl/core/greedy_text_line_wrapper_unit.sv
// Greedy text line wrapper: one character per cycle in while the record queue has room, line records out.
// Depends on gltw_pkg, gltw_step and gltw_rec_fifo.
//
// Characters are registered on input; once the queue has room the
// break decision runs and its line records (up to three for one character)
// go into a small record queue that feeds the output one record per cycle
// while the output is ready. The first record of a character passes the
// input register and the record queue before it is offered on the output.
// Input is taken every cycle as long as the queue has space for three
// records, so the sustained rate is one character per cycle while the
// output keeps up, and one record per cycle when records pile up.
module greedy_text_line_wrapper_unit
    import gltw_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration writes: index 0 wrap_width, index 1 min_width.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] char_code, [23:16] advance
    input  logic        s_axis_tlast,   // last_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [11:0] line_start, [24:12] line_length, zeros above
    output logic        m_axis_tuser    // record_kind
);

    logic [WRAP_W-1:0]  wrap_width_reg;
    logic [MINW_W-1:0]  min_width_reg;

    logic               in_valid_reg;
    logic [CODE_W-1:0]  in_code_reg;
    logic [ADV_W-1:0]   in_adv_reg;
    logic               in_last_reg;

    gltw_state_t        state_reg, state_next;
    gltw_rec_t [MAX_RECS-1:0] recs;
    logic [REC_CNT_W-1:0]     rec_count;
    logic               room;
    logic               step_fire;
    logic               head_valid;
    gltw_rec_t          head;

    assign cfg_ready     = 1'b1;
    assign step_fire     = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || step_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_width_reg <= WRAP_WIDTH_RESET;
            min_width_reg  <= MIN_WIDTH_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_WRAP_WIDTH: wrap_width_reg <= cfg_data;
                CFG_MIN_WIDTH:  min_width_reg  <= cfg_data[MINW_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (step_fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_code_reg <= s_axis_tdata[15:0];
            in_adv_reg  <= s_axis_tdata[23:16];
            in_last_reg <= s_axis_tlast;
        end
    end

    gltw_step u_step (
        .state_cur  (state_reg),
        .code       (in_code_reg),
        .adv        (in_adv_reg),
        .last       (in_last_reg),
        .wrap_width (wrap_width_reg),
        .min_width  (min_width_reg),
        .state_nxt  (state_next),
        .recs       (recs),
        .rec_count  (rec_count)
    );

    gltw_rec_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (step_fire),
        .push_count (rec_count),
        .push_recs  (recs),
        .room       (room),
        .pop        (m_axis_tready),
        .head_valid (head_valid),
        .head       (head)
    );

    assign m_axis_tvalid = head_valid;
    assign m_axis_tuser  = head.kind;
    assign m_axis_tdata  = {7'b0, head.len, head.start};

endmodule
